/* hw/rtl/pwv_pkg.sv */
package pwv_pkg;

    localparam int PIXELS_DEF = 4096;

    typedef struct packed {
        logic        [11:0] pixel_index;
        logic signed [31:0] sample;
        logic        [23:0] frame_count;
    } t_in;

    typedef struct packed {
        logic        [11:0] pixel_out;
        logic signed [31:0] mean;
        logic        [63:0] variance;
        logic        [31:0] std_dev;
        logic               variance_valid;
    } t_out;

endpackage

/* hw/rtl/per_pixel_welford_variance_unit.sv */
// Throughput: one beat per cycle while the output is not stalled; an input beat whose pixel matches one of the 14
// update stages (memory read through write back) waits until that item writes back.
// Sample variance division (4 quotient bits per stage) and square root (2 root bits
// per stage) are pipelined after the write back; the output stage stalls the pipe.
// Reset is synchronous, active low, and clears the valid bits; the statistics memory is not cleared.
module per_pixel_welford_variance_unit
    import pwv_pkg::*;
#(
    parameter int PIXELS = PIXELS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int SW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int NS     = 46;
    localparam int WB     = 13;
    localparam int LAST   = NS - 1;

    typedef struct packed {
        logic        [11:0] pix;
        logic     [SW-1:0]  slot;
        logic signed [31:0] x;
        logic        [23:0] k;
        logic        [23:0] kv;
        logic signed [31:0] old_m;
        logic        [63:0] old_sum;
        logic               d_neg;
        logic        [32:0] d_mag;
        logic        [35:0] num;
        logic        [23:0] rem;
        logic        [35:0] quo;
        logic signed [31:0] new_m;
        logic        [32:0] e_mag;
        logic        [48:0] pp_lo;
        logic        [49:0] pp_hi;
        logic        [63:0] sum;
        logic               vv;
        logic        [63:0] vnum;
        logic        [23:0] vrem;
        logic        [63:0] vquo;
        logic        [63:0] sq_src;
        logic        [33:0] sq_rem;
        logic        [31:0] root;
    } t_st;

    function automatic logic [SW-1:0] slot_mod(logic [11:0] v);
        logic [11:0] r;
        logic [63:0] pj;
        r = v;
        for (int j = 11; j >= 0; j--) begin
            pj = 64'(PIXELS) << j;
            if (pj <= 64'd4095) begin
                if ({52'b0, r} >= pj) begin
                    r = r - pj[11:0];
                end
            end
        end
        return SW'(r);
    endfunction

    function automatic t_st mean_div(t_st s);
        logic [24:0] rr;
        for (int j = 0; j < 4; j++) begin
            rr    = {s.rem, s.num[35]};
            s.num = {s.num[34:0], 1'b0};
            if (rr >= {1'b0, s.k}) begin
                rr    = rr - {1'b0, s.k};
                s.quo = {s.quo[34:0], 1'b1};
            end else begin
                s.quo = {s.quo[34:0], 1'b0};
            end
            s.rem = rr[23:0];
        end
        return s;
    endfunction

    function automatic t_st var_div(t_st s);
        logic [24:0] rr;
        for (int j = 0; j < 4; j++) begin
            rr     = {s.vrem, s.vnum[63]};
            s.vnum = {s.vnum[62:0], 1'b0};
            if (rr >= {1'b0, s.kv}) begin
                rr     = rr - {1'b0, s.kv};
                s.vquo = {s.vquo[62:0], 1'b1};
            end else begin
                s.vquo = {s.vquo[62:0], 1'b0};
            end
            s.vrem = rr[23:0];
        end
        return s;
    endfunction

    function automatic t_st root_step(t_st s);
        logic [35:0] rr;
        logic [35:0] trial;
        for (int j = 0; j < 2; j++) begin
            rr       = {s.sq_rem, s.sq_src[63:62]};
            s.sq_src = {s.sq_src[61:0], 2'b00};
            trial    = {2'b00, s.root, 2'b01};
            if (rr >= trial) begin
                rr     = rr - trial;
                s.root = {s.root[30:0], 1'b1};
            end else begin
                s.root = {s.root[30:0], 1'b0};
            end
            s.sq_rem = rr[33:0];
        end
        return s;
    endfunction

    function automatic t_st stage_fn(int i, t_st p);
        t_st         s;
        logic [32:0] d;
        logic [33:0] q;
        logic [33:0] nm;
        logic [32:0] e;
        logic [65:0] prod;
        logic [64:0] acc;
        s = p;
        if (i == 1) begin
            d       = {s.x[31], s.x} - {s.old_m[31], s.old_m};
            s.d_neg = d[32];
            s.d_mag = d[32] ? (33'd0 - d) : d;
            s.num   = {3'b000, s.d_mag};
            s.rem   = '0;
            s.quo   = '0;
        end else if (i >= 2 && i <= 10) begin
            s = mean_div(s);
        end else if (i == 11) begin
            q       = s.d_neg ? (34'd0 - s.quo[33:0]) : s.quo[33:0];
            nm      = {{2{s.old_m[31]}}, s.old_m} + q;
            s.new_m = nm[31:0];
            e       = {s.x[31], s.x} - {nm[31], nm[31:0]};
            s.e_mag = e[32] ? (33'd0 - e) : e;
        end else if (i == 12) begin
            s.pp_lo = s.d_mag * s.e_mag[15:0];
            s.pp_hi = s.d_mag * s.e_mag[32:16];
        end else if (i == 13) begin
            prod = {17'b0, s.pp_lo} + {s.pp_hi, 16'b0};
            acc  = {1'b0, s.old_sum} + {1'b0, prod[63:0]};
            if (s.k == 24'd1) begin
                s.sum = '0;
                s.kv  = 24'd1;
                s.vv  = 1'b0;
            end else begin
                s.sum = acc[64] ? '1 : acc[63:0];
                s.kv  = s.k - 24'd1;
                s.vv  = 1'b1;
            end
            s.vnum = s.sum;
            s.vrem = '0;
            s.vquo = '0;
        end else if (i >= 14 && i <= 29) begin
            s = var_div(s);
            if (i == 29) begin
                if (!s.vv) begin
                    s.vquo = '0;
                end
                s.sq_src = s.vquo;
                s.sq_rem = '0;
                s.root   = '0;
            end
        end else if (i >= 30) begin
            s = root_step(s);
        end
        return s;
    endfunction

    t_st             r_st [NS];
    t_st             n_st [NS];
    logic [NS-1:0]   r_v;
    logic [95:0]     r_mem [PIXELS];
    logic [95:0]     r_rd;
    logic            en;
    logic            hazard;
    logic            in_acc;
    logic [SW-1:0]   in_slot;
    t_st             s1_in;

    assign en      = !r_v[LAST] || i_ready;
    assign in_slot = slot_mod(i_data.pixel_index);

    always_comb begin
        hazard = 1'b0;
        for (int i = 0; i <= WB; i++) begin
            if (r_v[i] && r_st[i].slot == in_slot) begin
                hazard = 1'b1;
            end
        end
    end

    assign o_ready = en && !hazard;
    assign in_acc  = i_valid && o_ready;

    // first sample of a pixel: drop the stored mean, the slot may be unwritten
    always_comb begin
        n_st[0]       = r_st[0];
        n_st[0].pix   = i_data.pixel_index;
        n_st[0].slot  = in_slot;
        n_st[0].x     = i_data.sample;
        n_st[0].k     = (i_data.frame_count == 24'd0) ? 24'd1 : i_data.frame_count;
        s1_in         = r_st[0];
        s1_in.old_m   = (r_st[0].k == 24'd1) ? 32'sd0 : r_rd[95:64];
        s1_in.old_sum = r_rd[63:0];
    end

    for (genvar g = 1; g < NS; g++) begin : g_stage
        if (g == 1) begin : g_first
            assign n_st[g] = stage_fn(g, s1_in);
        end else begin : g_rest
            assign n_st[g] = stage_fn(g, r_st[g-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NS-2:0], in_acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NS; i++) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd <= r_mem[in_slot];
        end
        if (en && r_v[WB]) begin
            r_mem[r_st[WB].slot] <= {r_st[WB].new_m, r_st[WB].sum};
        end
    end

    assign o_valid               = r_v[LAST];
    assign o_data.pixel_out      = r_st[LAST].pix;
    assign o_data.mean           = r_st[LAST].new_m;
    assign o_data.variance       = r_st[LAST].vquo;
    assign o_data.std_dev        = r_st[LAST].root;
    assign o_data.variance_valid = r_st[LAST].vv;

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[LAST] && !i_ready) |=> r_v[LAST])
        else $error("output beat dropped while stalled");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_v[0])
        else $error("accepted beat missing from first stage");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.variance_valid) |->
            (o_data.variance == 64'd0 && o_data.std_dev == 32'd0))
        else $error("variance not zero when flagged invalid");

    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({32'd0, o_data.std_dev} * {32'd0, o_data.std_dev} <= o_data.variance))
        else $error("std_dev exceeds root of variance");

endmodule
